// ----- hdl/text_console_cursor_scroll_macros.svh -----
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

// Checks that hold on every clock edge outside reset.
`define TCCS_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define TCCS_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/tccs_pkg.sv -----
package tccs_pkg;

  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int PROBE_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

  localparam logic [MODE_W-1:0] MODE_PRINT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEWLINE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PROBE   = 2'd3;

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_PROBE
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY,
    ST_BLANK,
    ST_CLEAR,
    ST_PROBE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [CHAR_W-1:0]  char_code;
    logic [PROBE_W-1:0] probe_addr;
    logic               probe_ok;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] content;
    logic              scrolled;
  } res_t;

endpackage

// ----- hdl/tccs_ram.sv -----
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/tccs_fifo.sv -----
module tccs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW:0]      wptr;
  logic [AW:0]      rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign rdata = slots[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr[AW-1:0]] <= wdata;
    end
  end

endmodule

// ----- hdl/tccs_front.sv -----
module tccs_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         push,
  output logic                         full,
  input  logic [tccs_pkg::MODE_W-1:0]  mode,
  input  logic [tccs_pkg::CHAR_W-1:0]  char_code,
  input  logic [tccs_pkg::PROBE_W-1:0] probe_index,
  input  logic                         queue_full,
  input  logic                         init_busy,
  output logic                         cmd_push,
  output tccs_pkg::cmd_t               cmd
);

  localparam int CELLS = ROWS * COLUMNS;

  // Nothing is taken while the screen store is still being wiped after reset.
  assign full     = queue_full || init_busy;
  assign cmd_push = push && !full;

  always_comb begin
    cmd.char_code  = char_code;
    cmd.probe_addr = probe_index;
    cmd.probe_ok   = (32'(probe_index) < 32'(CELLS));
    case (mode)
      tccs_pkg::MODE_PRINT:   cmd.op = tccs_pkg::OP_PRINT;
      tccs_pkg::MODE_NEWLINE: cmd.op = tccs_pkg::OP_NEWLINE;
      tccs_pkg::MODE_CLEAR:   cmd.op = tccs_pkg::OP_CLEAR;
      tccs_pkg::MODE_PROBE:   cmd.op = tccs_pkg::OP_PROBE;
      default:                cmd.op = tccs_pkg::OP_PROBE;
    endcase
  end

endmodule

// ----- hdl/tccs_back.sv -----
module tccs_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  tccs_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output tccs_pkg::res_t              res,
  input  logic [tccs_pkg::ATTR_W-1:0] attr,
  output logic                        init_busy
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int PW     = $clog2(CELLS + 1);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int POS_W  = tccs_pkg::POS_W;
  localparam int CELL_W = tccs_pkg::CELL_W;

  localparam logic [AW-1:0] LAST_ROW_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL      = AW'(CELLS - 1);
  localparam logic [PW-1:0] PTR_LAST       = PW'(CELLS - 1);
  localparam logic [PW-1:0] PTR_END        = PW'(CELLS);
  localparam logic [PW-1:0] PTR_ROW1       = PW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST       = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST       = RW'(ROWS - 1);

  tccs_pkg::state_t state, state_next;

  tccs_pkg::cmd_t cur, cur_next;
  logic [AW-1:0]  lin, lin_next;
  logic [CW-1:0]  col, col_next;
  logic [RW-1:0]  row, row_next;
  logic           scr, scr_next;
  logic           fwd, fwd_next;
  logic [PW-1:0]  rd_ptr, rd_ptr_next;
  logic [PW-1:0]  wr_ptr, wr_ptr_next;
  logic           pend, pend_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic start;
  logic at_last_cell;
  logic at_last_row;
  logic do_rd;

  assign start        = cmd_valid && !res_full;
  assign at_last_cell = (lin == LAST_CELL);
  assign at_last_row  = (row == ROW_LAST);
  assign do_rd        = (rd_ptr != PTR_END);
  assign init_busy    = (state == tccs_pkg::ST_INIT);

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      tccs_pkg::ST_INIT: begin
        if (wr_ptr == PTR_LAST) begin
          state_next = tccs_pkg::ST_IDLE;
        end
      end
      tccs_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd.op)
            tccs_pkg::OP_PRINT: begin
              state_next = at_last_cell ? tccs_pkg::ST_COPY : tccs_pkg::ST_RESULT;
            end
            tccs_pkg::OP_NEWLINE: begin
              state_next = at_last_row ? tccs_pkg::ST_COPY : tccs_pkg::ST_RESULT;
            end
            tccs_pkg::OP_CLEAR: state_next = tccs_pkg::ST_CLEAR;
            default:            state_next = tccs_pkg::ST_RESULT;
          endcase
        end
      end
      tccs_pkg::ST_COPY: begin
        if (!do_rd && !pend) begin
          state_next = tccs_pkg::ST_BLANK;
        end
      end
      tccs_pkg::ST_BLANK, tccs_pkg::ST_CLEAR: begin
        if (wr_ptr == PTR_LAST) begin
          state_next = tccs_pkg::ST_PROBE;
        end
      end
      tccs_pkg::ST_PROBE:  state_next = tccs_pkg::ST_RESULT;
      tccs_pkg::ST_RESULT: state_next = tccs_pkg::ST_IDLE;
      default:             state_next = tccs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr[AW-1:0];
    mem_wdata   = '0;
    mem_raddr   = AW'(cur.probe_addr);
    cur_next    = cur;
    lin_next    = lin;
    col_next    = col;
    row_next    = row;
    scr_next    = scr;
    fwd_next    = fwd;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    pend_next   = pend;

    res.pos      = POS_W'(lin);
    res.scrolled = scr;
    if (!cur.probe_ok) begin
      res.content = '0;
    end else if (fwd) begin
      res.content = {attr, cur.char_code};
    end else begin
      res.content = mem_rdata;
    end

    case (state)
      tccs_pkg::ST_INIT, tccs_pkg::ST_BLANK, tccs_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        wr_ptr_next = wr_ptr + 1'b1;
      end
      tccs_pkg::ST_IDLE: begin
        // The probe read goes out alongside the print write; a probe of the
        // cell just written is served from the command instead of the store.
        mem_raddr = AW'(cmd.probe_addr);
        if (start) begin
          cmd_pop     = 1'b1;
          cur_next    = cmd;
          scr_next    = 1'b0;
          fwd_next    = 1'b0;
          rd_ptr_next = PTR_ROW1;
          wr_ptr_next = '0;
          pend_next   = 1'b0;
          case (cmd.op)
            tccs_pkg::OP_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = lin;
              mem_wdata = {attr, cmd.char_code};
              fwd_next  = cmd.probe_ok && (AW'(cmd.probe_addr) == lin) && !at_last_cell;
              if (at_last_cell) begin
                col_next = '0;
                lin_next = LAST_ROW_START;
                scr_next = 1'b1;
              end else if (col == COL_LAST) begin
                col_next = '0;
                row_next = row + 1'b1;
                lin_next = lin + 1'b1;
              end else begin
                col_next = col + 1'b1;
                lin_next = lin + 1'b1;
              end
            end
            tccs_pkg::OP_NEWLINE: begin
              col_next = '0;
              if (at_last_row) begin
                lin_next = LAST_ROW_START;
                scr_next = 1'b1;
              end else begin
                row_next = row + 1'b1;
                lin_next = lin + AW'(COLUMNS) - AW'(col);
              end
            end
            tccs_pkg::OP_CLEAR: begin
              lin_next = '0;
              col_next = '0;
              row_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      tccs_pkg::ST_COPY: begin
        // Row shift: read one row below, write the word back in the cycle after.
        mem_raddr = rd_ptr[AW-1:0];
        pend_next = do_rd;
        if (do_rd) begin
          rd_ptr_next = rd_ptr + 1'b1;
        end
        if (pend) begin
          mem_we      = 1'b1;
          mem_wdata   = mem_rdata;
          wr_ptr_next = wr_ptr + 1'b1;
        end
      end
      tccs_pkg::ST_PROBE: begin
        fwd_next = 1'b0;
      end
      tccs_pkg::ST_RESULT: begin
        res_push = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tccs_pkg::ST_INIT;
      lin    <= '0;
      col    <= '0;
      row    <= '0;
      scr    <= 1'b0;
      fwd    <= 1'b0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      lin    <= lin_next;
      col    <= col_next;
      row    <= row_next;
      scr    <= scr_next;
      fwd    <= fwd_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      pend   <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

endmodule

// ----- hdl/text_console_cursor_scroll.sv -----
// Text console writer with a ROWS x COLUMNS store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a linear cursor. Words go in through a
// two-entry command queue and results come out of a two-entry result queue, so a
// single waiting result does not block the input. After reset the store is wiped one
// cell per cycle and full stays high until it is done. Print or newline with no scroll,
// and probe, go from idle straight to the result state; the store has one write port
// and a registered read. Clear wipes the store and a scroll moves each row up and
// blanks the last; both walk it one cell per cycle. The user must write the text
// attribute through cfg_we/cfg_wdata only while the block is idle; it is not checked.
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [tccs_pkg::MODE_W-1:0]  mode,
  input  logic [tccs_pkg::CHAR_W-1:0]  char_code,
  input  logic [tccs_pkg::PROBE_W-1:0] probe_index,
  input  logic                         cfg_we,
  input  logic [tccs_pkg::ATTR_W-1:0]  cfg_wdata,
  output logic                         empty,
  input  logic                         pop,
  output logic [tccs_pkg::POS_W-1:0]   cursor_position,
  output logic [tccs_pkg::CELL_W-1:0]  probe_cell,
  output logic                         scrolled
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int POS_W = tccs_pkg::POS_W;
  localparam logic [POS_W-1:0] SCROLL_POS = POS_W'(CELLS - COLUMNS);

  logic [tccs_pkg::ATTR_W-1:0] text_attribute;

  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_empty;
  logic           cmd_pop;
  tccs_pkg::cmd_t cmd_in;
  tccs_pkg::cmd_t cmd_out;
  logic           res_push;
  logic           res_full;
  tccs_pkg::res_t res_in;
  tccs_pkg::res_t res_out;
  logic           init_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= tccs_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      text_attribute <= cfg_wdata;
    end
  end

  tccs_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .push        (push),
    .full        (full),
    .mode        (mode),
    .char_code   (char_code),
    .probe_index (probe_index),
    .queue_full  (cmd_full),
    .init_busy   (init_busy),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  tccs_fifo #(
    .WIDTH ($bits(tccs_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  tccs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .attr      (text_attribute),
    .init_busy (init_busy)
  );

  tccs_fifo #(
    .WIDTH ($bits(tccs_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign cursor_position = res_out.pos;
  assign probe_cell      = res_out.content;
  assign scrolled        = res_out.scrolled;

`include "text_console_cursor_scroll_macros.svh"

  `TCCS_IMPLY(a_res_no_overflow, res_push, !res_full, "result pushed into a full queue")
  `TCCS_CHECK(a_cmd_no_underflow, !(cmd_pop && cmd_empty), "command popped from empty queue")
  `TCCS_IMPLY(a_init_blocks_input, init_busy, full, "input open during the reset wipe")
  `TCCS_IMPLY(a_scroll_cursor, !empty && scrolled, cursor_position == SCROLL_POS, "bad cursor after scroll")

endmodule
